FILE: hw/rtl/srtf_pkg.sv
// shared types, constants and helper functions of the srtf scheduler
`timescale 1ns / 1ps
package srtf_pkg;

	localparam int SLOT_COUNT     = 8;
	localparam int IO_PER_PROCESS = 3;
	localparam int SLOT_W         = $clog2(SLOT_COUNT);
	localparam int CNT_W          = SLOT_W + 1;
	localparam int TIME_W         = 8;
	localparam int IDX_W          = 2;
	localparam int CFG_IDX_W      = 1;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// result kinds
	localparam logic [2:0] KIND_IO     = 3'd0;
	localparam logic [2:0] KIND_RAN    = 3'd1;
	localparam logic [2:0] KIND_IDLE   = 3'd2;
	localparam logic [2:0] KIND_DONE   = 3'd3;
	localparam logic [2:0] KIND_HALTED = 3'd4;
	localparam logic [2:0] KIND_LOADED = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME    = 1'd1;

	typedef struct packed {
		logic [7:0] len;
		logic [7:0] at;
	} io_ent_t;

	typedef io_ent_t [IO_PER_PROCESS-1:0] io_row_t;

	typedef struct packed {
		logic              mode;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        arrival;
		logic [7:0]        burst;
		logic [IDX_W-1:0]  io_count;
		io_row_t           io;
	} item_t;

	// per-slot dynamic record held in the slot memory
	typedef struct packed {
		logic [7:0]       arrival;
		logic [7:0]       burst;
		logic [7:0]       remaining;
		logic [IDX_W-1:0] io_count;
		logic [IDX_W-1:0] io_next;
		logic [7:0]       io_left;
		logic             in_wait;
	} slot_rec_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [3:0]        pid;
		logic [TIME_W-1:0] tick;
		logic [7:0]        turnaround;
		logic [7:0]        wait_total;
		logic              all_done;
	} res_t;

	function automatic logic [CNT_W-1:0] used_slots(input logic [3:0] cfg);
		logic [CNT_W-1:0] n;
		n = CNT_W'(cfg);
		if (cfg == 4'd0)
			n = CNT_W'(1);
		else if ({1'b0, cfg} > 5'(SLOT_COUNT))
			n = CNT_W'(SLOT_COUNT);
		return n;
	endfunction

	function automatic slot_rec_t io_countdown(input slot_rec_t r);
		slot_rec_t o;
		o = r;
		if (r.in_wait) begin
			if (r.io_left <= 8'd1) begin
				o.io_left = 8'd0;
				o.in_wait = 1'b0;
			end else begin
				o.io_left = r.io_left - 8'd1;
			end
		end
		return o;
	endfunction

	function automatic logic all_finished(input logic [SLOT_COUNT-1:0] fin,
			input logic [CNT_W-1:0] n);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < SLOT_COUNT; i++)
			if (CNT_W'(i) < n && !fin[i])
				ok = 1'b0;
		return ok;
	endfunction

endpackage

FILE: hw/rtl/srtf_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps
module srtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/srtf_sched.sv
// scheduling sequencer: slot scan over the slot memory, selection and commit
`timescale 1ns / 1ps
module srtf_sched import srtf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  item_t             in_item,
	input  logic [CNT_W-1:0]  n_used,
	input  logic [7:0]        stop_time,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOAD   = 3'd1;
	localparam logic [2:0] ST_STEP   = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;

	localparam int REC_W = $bits(slot_rec_t);
	localparam int ROW_W = $bits(io_row_t);

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TIME_W-1:0]     tick_q;
	logic                  halted_q;
	logic                  pend_q;
	logic [SLOT_COUNT-1:0] fin_q;
	logic                  best_valid_q;
	logic                  rd_valid_s1;
	logic [SLOT_W-1:0]     rd_slot_s1;
	item_t                 item_q;
	logic [SLOT_W-1:0]     best_slot_q;
	slot_rec_t             best_rec_q;
	io_row_t               best_io_q;

	// memory ports
	logic              rec_we;
	logic [SLOT_W-1:0] rec_waddr;
	slot_rec_t         rec_wdata;
	logic              rd_en;
	logic [SLOT_W-1:0] rd_addr;
	logic [REC_W-1:0]  rec_rdata;
	logic [ROW_W-1:0]  io_rdata;
	logic              io_we;

	srtf_ram #(.WIDTH(REC_W), .DEPTH(SLOT_COUNT)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rec_rdata)
	);

	srtf_ram #(.WIDTH(ROW_W), .DEPTH(SLOT_COUNT)) u_io_ram (
		.clk   (clk),
		.we    (io_we),
		.waddr (item_q.slot),
		.wdata (item_q.io),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (io_rdata)
	);

	// scan stage: pending countdown applied on the way through
	slot_rec_t scan_rec;
	logic      cand;
	logic      better;

	always_comb begin
		scan_rec = pend_q ? io_countdown(slot_rec_t'(rec_rdata)) : slot_rec_t'(rec_rdata);
		cand = ({1'b0, rd_slot_s1} < n_used) && !fin_q[rd_slot_s1] && !scan_rec.in_wait &&
			(scan_rec.remaining != 8'd0) && (scan_rec.arrival <= tick_q);
		better = !best_valid_q || (scan_rec.remaining < best_rec_q.remaining) ||
			((scan_rec.remaining == best_rec_q.remaining) &&
			(scan_rec.arrival < best_rec_q.arrival));
	end

	assign rd_en   = (state_q == ST_SCAN) && (cnt_q < CNT_W'(SLOT_COUNT));
	assign rd_addr = cnt_q[SLOT_W-1:0];

	// commit stage decision
	logic [IDX_W-1:0]      idx;
	io_ent_t               ent;
	logic [8:0]            io_mark;
	logic                  io_hit;
	logic [7:0]            rem_dec;
	logic [TIME_W-1:0]     tick_inc;
	logic [8:0]            end9;
	logic [8:0]            tat9;
	logic [7:0]            tat8;
	logic [7:0]            wt8;
	logic [SLOT_COUNT-1:0] fin_done;
	logic [SLOT_COUNT-1:0] fin_load;
	slot_rec_t             commit_rec;
	slot_rec_t             load_rec;
	logic [IDX_W-1:0]      cnt_clamp;

	always_comb begin
		idx = best_rec_q.io_next;
		case (idx)
			2'd0:    ent = best_io_q[0];
			2'd1:    ent = best_io_q[1];
			2'd2:    ent = best_io_q[2];
			default: ent = '0;
		endcase
		io_mark = {1'b0, best_rec_q.burst} - {1'b0, ent.at};
		io_hit  = best_valid_q && (idx < best_rec_q.io_count) && !io_mark[8] &&
			(io_mark[7:0] == best_rec_q.remaining);
		rem_dec  = best_rec_q.remaining - 8'd1;
		tick_inc = (tick_q == TIME_MAX) ? tick_q : tick_q + TIME_W'(1);

		end9 = {1'b0, tick_q} + 9'd1;
		tat9 = (end9 > {1'b0, best_rec_q.arrival}) ? end9 - {1'b0, best_rec_q.arrival} : 9'd0;
		tat8 = tat9[8] ? 8'hff : tat9[7:0];
		wt8  = (tat8 > best_rec_q.burst) ? tat8 - best_rec_q.burst : 8'd0;

		fin_done = fin_q;
		fin_done[best_slot_q] = 1'b1;
		fin_load = fin_q;
		fin_load[item_q.slot] = 1'b0;

		commit_rec = best_rec_q;
		if (io_hit) begin
			commit_rec.io_left = (ent.len == 8'd0) ? 8'd1 : ent.len;
			commit_rec.in_wait = 1'b1;
			commit_rec.io_next = idx + IDX_W'(1);
		end else begin
			commit_rec.remaining = rem_dec;
		end

		cnt_clamp = ({1'b0, item_q.io_count} > 3'(IO_PER_PROCESS)) ?
			IDX_W'(IO_PER_PROCESS) : item_q.io_count;
		load_rec.arrival   = item_q.arrival;
		load_rec.burst     = item_q.burst;
		load_rec.remaining = item_q.burst;
		load_rec.io_count  = cnt_clamp;
		load_rec.io_next   = '0;
		load_rec.io_left   = 8'd0;
		load_rec.in_wait   = 1'b0;
	end

	logic step_stop;
	assign step_stop = halted_q || all_finished(fin_q, n_used);

	// result and memory writes
	always_comb begin
		res_valid      = 1'b0;
		res.kind       = KIND_HALTED;
		res.pid        = 4'd0;
		res.tick       = tick_q;
		res.turnaround = 8'd0;
		res.wait_total = 8'd0;
		res.all_done   = all_finished(fin_q, n_used);
		rec_we         = 1'b0;
		rec_waddr      = rd_slot_s1;
		rec_wdata      = scan_rec;
		io_we          = 1'b0;
		case (state_q)
			ST_LOAD: begin
				res_valid    = 1'b1;
				res.kind     = KIND_LOADED;
				res.pid      = 4'({1'b0, item_q.slot}) + 4'd1;
				res.all_done = all_finished(fin_load, n_used);
				rec_we       = res_ready;
				rec_waddr    = item_q.slot;
				rec_wdata    = load_rec;
				io_we        = res_ready;
			end
			ST_STEP: begin
				res_valid = step_stop;
			end
			ST_SCAN: begin
				rec_we = rd_valid_s1;
			end
			ST_COMMIT: begin
				res_valid = 1'b1;
				rec_waddr = best_slot_q;
				rec_wdata = commit_rec;
				if (!best_valid_q) begin
					res.kind = KIND_IDLE;
				end else begin
					res.pid = 4'({1'b0, best_slot_q}) + 4'd1;
					rec_we  = res_ready;
					if (io_hit) begin
						res.kind = KIND_IO;
					end else if (rem_dec == 8'd0) begin
						res.kind       = KIND_DONE;
						res.turnaround = tat8;
						res.wait_total = wt8;
						res.all_done   = all_finished(fin_done, n_used);
					end else begin
						res.kind = KIND_RAN;
					end
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			tick_q       <= '0;
			halted_q     <= 1'b0;
			pend_q       <= 1'b0;
			fin_q        <= '0;
			best_valid_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (rd_valid_s1 && cand && better)
				best_valid_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= in_item.mode ? ST_STEP : ST_LOAD;
				end
				ST_LOAD: begin
					if (res_ready) begin
						fin_q    <= fin_load;
						tick_q   <= '0;
						halted_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				ST_STEP: begin
					if (!step_stop) begin
						cnt_q        <= '0;
						best_valid_q <= 1'b0;
						state_q      <= ST_SCAN;
					end else if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (rd_en)
						cnt_q <= cnt_q + CNT_W'(1);
					else
						state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
						if (best_valid_q && io_hit) begin
							pend_q <= 1'b0;
						end else begin
							pend_q <= 1'b1;
							tick_q <= tick_inc;
							if (best_valid_q && rem_dec == 8'd0)
								fin_q <= fin_done;
							else if (tick_inc > stop_time)
								halted_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_q <= in_item;
		if (rd_en)
			rd_slot_s1 <= rd_addr;
		if (rd_valid_s1 && cand && better) begin
			best_slot_q <= rd_slot_s1;
			best_rec_q  <= scan_rec;
			best_io_q   <= io_row_t'(io_rdata);
		end
	end

	// chosen slot must still have work left
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT) && best_valid_q |-> best_rec_q.remaining != 8'd0)
		else $error("chosen slot has no remaining time");

	// halt only when time has passed the stop time
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(halted_q) |-> tick_q > stop_time)
		else $error("halted before stop time");

	// finished flags only move on a load or a commit
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fin_q) |-> $past(state_q == ST_LOAD || state_q == ST_COMMIT))
		else $error("finished flags changed outside load or commit");

	// time either restarts or steps by one
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tick_q) |-> (tick_q == '0) || (tick_q == $past(tick_q) + TIME_W'(1)))
		else $error("current tick jumped");

endmodule

FILE: hw/rtl/srtf_scheduler_with_io_waits_core.sv
// top level: stream ports, configuration registers and output register
`timescale 1ns / 1ps
// Shortest-remaining-time-first scheduler with I/O waits. A load transaction
// (tuser 0) writes one slot descriptor and restarts time; a step transaction
// (tuser 1) runs one scheduler pass and returns one result. Per-slot state
// lives in a slot-record memory and an I/O-table memory, each one word per
// slot. A step while halted or with all slots done returns a result with no
// scan. A scheduling step scans the slots: the scan reads, updates and writes
// back one slot per cycle through the single read port of the slot-record
// memory, then the commit state updates the chosen slot. The result sits in
// an output register, so the next transaction is taken while it waits. The
// user must write configuration only while the block is idle; the block
// itself does not enforce it. Memories need no clearing after reset.
module srtf_scheduler_with_io_waits_core import srtf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// slot[2:0], arrival[10:3], burst[18:11], io_count[20:19],
	// io_at_first[28:21], io_at_second[36:29], io_at_third[44:37],
	// io_len_first[52:45], io_len_second[60:53], io_len_third[68:61]
	input  logic [71:0]          s_tdata,
	// mode
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// pid[3:0], tick[11:4], turnaround[19:12], wait_total[27:20], all_done[28]
	output logic [31:0]          m_tdata,
	// kind
	output logic [2:0]           m_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [3:0] slots_in_use_q;
	logic [7:0] stop_time_q;
	item_t      item;
	logic       res_valid;
	logic       res_ready;
	res_t       res;
	res_t       out_q;
	logic       out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= 4'd5;
			stop_time_q    <= 8'd198;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SLOTS_IN_USE: slots_in_use_q <= cfg_data[3:0];
				REG_STOP_TIME:    stop_time_q    <= cfg_data;
				default:          stop_time_q    <= stop_time_q;
			endcase
		end
	end

	always_comb begin
		item.mode      = s_tuser;
		item.slot      = s_tdata[2:0];
		item.arrival   = s_tdata[10:3];
		item.burst     = s_tdata[18:11];
		item.io_count  = s_tdata[20:19];
		item.io[0].at  = s_tdata[28:21];
		item.io[1].at  = s_tdata[36:29];
		item.io[2].at  = s_tdata[44:37];
		item.io[0].len = s_tdata[52:45];
		item.io[1].len = s_tdata[60:53];
		item.io[2].len = s_tdata[68:61];
	end

	srtf_sched u_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.n_used    (used_slots(slots_in_use_q)),
		.stop_time (stop_time_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_valid && res_ready)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {3'b000, out_q.all_done, out_q.wait_total, out_q.turnaround,
		out_q.tick, out_q.pid};

endmodule
